[rtl/core/mlpd_pkg.sv]
// ----------------------------------------------------------------------------
// Meter LCD packet decoder package
// Shared status codes, register indexes and the seven-segment lookup used by
// the decoder and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package mlpd_pkg;

  // Number of nibble positions in one packet.
  localparam int unsigned PacketPositions = 14;
  localparam int unsigned NibbleW         = 4;
  localparam int unsigned PosW            = 4;
  localparam int unsigned SegPatternW     = 7;
  localparam int unsigned SegEntries      = 12;

  // Position value that closes a packet.
  localparam logic [PosW-1:0] PosLast    = 4'(PacketPositions);
  // Position value that is never valid, besides zero.
  localparam logic [PosW-1:0] PosInvalid = 4'd15;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_METER_ON  = 3'd1,
    ST_INVALID   = 3'd2,
    ST_SHORT     = 3'd3,
    ST_TOO_MANY  = 3'd4,
    ST_BAD_DIGIT = 3'd5
  } status_e;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    CFG_MIN_PACKET  = 1'b0,
    CFG_MAX_ATTEMPT = 1'b1
  } cfg_idx_e;

  // Segment patterns of the display characters: 0-9, L, blank.
  localparam logic [SegPatternW-1:0] SegTable [SegEntries] = '{
    7'h7D, 7'h05, 7'h5B, 7'h1F, 7'h27, 7'h3E,
    7'h7E, 7'h15, 7'h7F, 7'h3F, 7'h68, 7'h00
  };

  typedef struct packed {
    logic       hit;
    logic [3:0] digit;
  } seg_res_t;

  // Finds the character code of a segment pattern; hit is low if unknown.
  function automatic seg_res_t seg_lookup(input logic [SegPatternW-1:0] pat);
    seg_res_t res;
    res = '0;
    for (int k = 0; k < SegEntries; k++) begin
      if (!res.hit && SegTable[k] == pat) begin
        res.hit   = 1'b1;
        res.digit = 4'(k);
      end
    end
    return res;
  endfunction

endpackage

`default_nettype wire

[rtl/core/meter_lcd_packet_decoder_unit.sv]
// ----------------------------------------------------------------------------
// Meter LCD packet decoder
// Collects position-tagged nibbles from a meter link and decodes each
// finished packet attempt into a status and the display contents.
// ----------------------------------------------------------------------------
// Usage:
//   Bytes arrive on the rx_byte request channel (valid/ready). The upper
//   nibble is a position from 1 to 14, the lower nibble is stored there.
//   Each packet attempt closes on a zero byte, an invalid position, the
//   position-14 byte, or too many stored bytes; exactly one request then
//   leaves on the result channel (valid/ready) with status, four digits,
//   minus sign, point marks and attribute mask. Bytes that do not close an
//   attempt produce no result.
//   A result is registered and shown in the cycle after its closing byte is taken.
//   Throughput: one byte per cycle while the input is not stalled; the store
//   update and the decode sit between the nibble store and the result register.
//   A pending result that is not taken only stalls the input while the
//   result register is full and the receiver holds ready low.
//   Reset clears the nibble store, the byte count and the result valid, and
//   loads min_packet_bytes = 13 and max_attempt_bytes = 15. The registers
//   are written through the cfg port at any clock edge with cfg_we_i high.
// ----------------------------------------------------------------------------
`default_nettype none

module meter_lcd_packet_decoder_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Configuration write port.
  input  wire logic        cfg_we_i,
  input  wire logic [0:0]  cfg_idx_i,
  input  wire logic [3:0]  cfg_data_i,
  // Input byte channel.
  input  wire logic        rx_byte_valid_i,
  output logic             rx_byte_ready_o,
  input  wire logic [7:0]  rx_byte_i,
  // Result channel.
  output logic             res_valid_o,
  input  wire logic        res_ready_i,
  output logic [2:0]       status_o,
  output logic [3:0]       digit_first_o,
  output logic [3:0]       digit_second_o,
  output logic [3:0]       digit_third_o,
  output logic [3:0]       digit_fourth_o,
  output logic             minus_sign_o,
  output logic [2:0]       point_marks_o,
  output logic [23:0]      attribute_mask_o
);

  localparam int unsigned NPos = mlpd_pkg::PacketPositions;
  localparam int unsigned NibW = mlpd_pkg::NibbleW;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  digit_first;
    logic [3:0]  digit_second;
    logic [3:0]  digit_third;
    logic [3:0]  digit_fourth;
    logic        minus_sign;
    logic [2:0]  point_marks;
    logic [23:0] attribute_mask;
  } result_t;

  logic [3:0]      min_bytes_q;
  logic [3:0]      max_bytes_q;
  logic [NibW-1:0] store_q [NPos];
  logic [NibW-1:0] view    [NPos];
  logic [3:0]      count_q, count_d, count_inc;
  logic            res_valid_q, res_valid_d;
  result_t         res_q, res_d, res_new;

  logic            accept;
  logic [3:0]      pos;
  logic [3:0]      wr_idx;
  logic            is_zero, is_bad, do_store, is_last, is_over, finish;
  logic            all_hit;
  mlpd_pkg::seg_res_t seg [4];
  mlpd_pkg::status_e  status;

  // The input is taken whenever the result register is free or being emptied.
  assign rx_byte_ready_o = !res_valid_q || res_ready_i;
  assign accept          = rx_byte_valid_i && rx_byte_ready_o;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_bytes_q <= 4'd13;
      max_bytes_q <= 4'd15;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        mlpd_pkg::CFG_MIN_PACKET:  min_bytes_q <= cfg_data_i;
        mlpd_pkg::CFG_MAX_ATTEMPT: max_bytes_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Byte classification.
  assign pos       = rx_byte_i[7:4];
  assign wr_idx    = pos - 4'd1;
  assign is_zero   = (rx_byte_i == 8'd0);
  assign is_bad    = !is_zero && (pos == 4'd0 || pos == mlpd_pkg::PosInvalid);
  assign do_store  = !is_zero && !is_bad;
  assign count_inc = count_q + 4'd1;
  assign is_last   = do_store && (pos == mlpd_pkg::PosLast);
  assign is_over   = do_store && !is_last && (count_inc >= max_bytes_q);
  assign finish    = is_zero || is_bad || is_last || is_over;

  // Store contents as seen after this byte is written.
  always_comb begin
    for (int k = 0; k < NPos; k++) begin
      view[k] = (do_store && wr_idx == 4'(k)) ? rx_byte_i[3:0] : store_q[k];
    end
  end

  // Segment lookups for the four display digits.
  always_comb begin
    for (int d = 0; d < 4; d++) begin
      seg[d] = mlpd_pkg::seg_lookup({view[1 + 2*d][2:0], view[2 + 2*d]});
    end
  end
  assign all_hit = seg[0].hit && seg[1].hit && seg[2].hit && seg[3].hit;

  // Status selection.
  always_comb begin
    if (is_zero) begin
      status = mlpd_pkg::ST_METER_ON;
    end else if (is_bad) begin
      status = mlpd_pkg::ST_INVALID;
    end else if (is_last) begin
      if (count_inc < min_bytes_q) begin
        status = mlpd_pkg::ST_SHORT;
      end else if (!all_hit) begin
        status = mlpd_pkg::ST_BAD_DIGIT;
      end else begin
        status = mlpd_pkg::ST_OK;
      end
    end else begin
      status = mlpd_pkg::ST_TOO_MANY;
    end
  end

  // Result assembly; the display fields are zero unless the packet is good.
  always_comb begin
    res_new        = '0;
    res_new.status = status;
    if (status == mlpd_pkg::ST_OK) begin
      res_new.digit_first    = seg[0].digit;
      res_new.digit_second   = seg[1].digit;
      res_new.digit_third    = seg[2].digit;
      res_new.digit_fourth   = seg[3].digit;
      res_new.minus_sign     = view[1][3];
      res_new.point_marks    = {view[7][3], view[5][3], view[3][3]};
      res_new.attribute_mask = {view[13], view[12], view[11], view[10], view[9], view[0]};
    end
  end

  // Byte count and result register next values.
  always_comb begin
    count_d     = count_q;
    res_valid_d = res_valid_q && !res_ready_i;
    res_d       = res_q;
    if (accept) begin
      if (finish) begin
        count_d     = 4'd0;
        res_valid_d = 1'b1;
        res_d       = res_new;
      end else begin
        count_d = count_inc;
      end
    end
  end

  // Nibble store: written on a stored byte, cleared when an attempt closes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NPos; k++) begin
        store_q[k] <= '0;
      end
    end else if (accept) begin
      for (int k = 0; k < NPos; k++) begin
        store_q[k] <= finish ? '0 : view[k];
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= 4'd0;
      res_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Result payload register.
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_valid_o      = res_valid_q;
  assign status_o         = res_q.status;
  assign digit_first_o    = res_q.digit_first;
  assign digit_second_o   = res_q.digit_second;
  assign digit_third_o    = res_q.digit_third;
  assign digit_fourth_o   = res_q.digit_fourth;
  assign minus_sign_o     = res_q.minus_sign;
  assign point_marks_o    = res_q.point_marks;
  assign attribute_mask_o = res_q.attribute_mask;

endmodule

`default_nettype wire

[rtl/core/mlpd_checker.sv]
// ----------------------------------------------------------------------------
// Meter LCD packet decoder checker
// Port-level assertions on the decoder, attached to the decoder module by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module mlpd_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        rx_byte_valid_i,
  input wire logic        rx_byte_ready_o,
  input wire logic [7:0]  rx_byte_i,
  input wire logic        res_valid_o,
  input wire logic        res_ready_i,
  input wire logic [2:0]  status_o,
  input wire logic [3:0]  digit_first_o,
  input wire logic [3:0]  digit_second_o,
  input wire logic [3:0]  digit_third_o,
  input wire logic [3:0]  digit_fourth_o,
  input wire logic        minus_sign_o,
  input wire logic [2:0]  point_marks_o,
  input wire logic [23:0] attribute_mask_o
);

  // A result request stays offered until it is taken.
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_ready_i |=> res_valid_o)
    else $error("result request dropped before it was taken");

  // A zero byte closes the attempt with the meter-on status.
  a_zero_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rx_byte_valid_i && rx_byte_ready_o && rx_byte_i == 8'd0
    |=> res_valid_o && status_o == mlpd_pkg::ST_METER_ON)
    else $error("zero byte did not give a meter-on result");

  // A nonzero byte with position zero or fifteen is reported as invalid.
  a_bad_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rx_byte_valid_i && rx_byte_ready_o && rx_byte_i != 8'd0 &&
    (rx_byte_i[7:4] == 4'd0 || rx_byte_i[7:4] == 4'd15)
    |=> res_valid_o && status_o == mlpd_pkg::ST_INVALID)
    else $error("invalid position did not give an invalid-byte result");

  // Failed attempts carry no display contents.
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && status_o != mlpd_pkg::ST_OK
    |-> digit_first_o == 4'd0 && digit_second_o == 4'd0 &&
        digit_third_o == 4'd0 && digit_fourth_o == 4'd0 &&
        !minus_sign_o && point_marks_o == 3'd0 && attribute_mask_o == 24'd0)
    else $error("failed attempt carries display fields");

  // Good packets only show known characters.
  a_ok_digits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && status_o == mlpd_pkg::ST_OK
    |-> digit_first_o <= 4'd11 && digit_second_o <= 4'd11 &&
        digit_third_o <= 4'd11 && digit_fourth_o <= 4'd11)
    else $error("good packet shows an unknown character code");

endmodule

bind meter_lcd_packet_decoder_unit mlpd_checker u_mlpd_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .rx_byte_valid_i  (rx_byte_valid_i),
  .rx_byte_ready_o  (rx_byte_ready_o),
  .rx_byte_i        (rx_byte_i),
  .res_valid_o      (res_valid_o),
  .res_ready_i      (res_ready_i),
  .status_o         (status_o),
  .digit_first_o    (digit_first_o),
  .digit_second_o   (digit_second_o),
  .digit_third_o    (digit_third_o),
  .digit_fourth_o   (digit_fourth_o),
  .minus_sign_o     (minus_sign_o),
  .point_marks_o    (point_marks_o),
  .attribute_mask_o (attribute_mask_o)
);

`default_nettype wire
